### rtl/core/mma_pkg.sv
// ----------------------------------------------------------------------------
// Moving average package
// Shared types, fixed field widths and width helpers for the per-channel
// sliding-window averaging core.
// ----------------------------------------------------------------------------
package mma_pkg;

  // Fixed widths of the beat fields.
  localparam int CHAN_BITS        = 3;
  localparam int PORT_SAMPLE_BITS = 12;
  localparam int AVG_BITS         = 12;
  localparam int PORT_CHANNELS    = 1 << CHAN_BITS;

  // Result buffer between the datapath and the output channel.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [CHAN_BITS-1:0]        chan_t;
  typedef logic [CHAN_BITS:0]          chan_wide_t;
  typedef logic [PORT_SAMPLE_BITS-1:0] sample_t;
  typedef logic [AVG_BITS-1:0]         avg_t;
  typedef logic [FIFO_AW-1:0]          fifo_ptr_t;
  typedef logic [FIFO_AW:0]            fifo_cnt_t;

  // Control that travels with a beat down the pipeline.
  typedef struct packed {
    logic valid;
    logic live;
  } beat_ctl_t;

  // Stored sample width: the port never carries more than its own width.
  function automatic int store_bits(input int sample_bits);
    return (sample_bits < PORT_SAMPLE_BITS) ? sample_bits : PORT_SAMPLE_BITS;
  endfunction

  // Window total width: exact sum of WINDOW stored samples.
  function automatic int total_bits(input int sample_bits, input int window);
    return store_bits(sample_bits) + $clog2(window);
  endfunction

endpackage

### rtl/core/multichannel_moving_average_core.sv
// ----------------------------------------------------------------------------
// Multichannel moving average core
// Per-channel sliding-window average of converter samples, rounded to
// nearest, one result beat for every sample beat.
// ----------------------------------------------------------------------------
//
//  Port group     | Dir | Handshake                   | Payload
//  ---------------+-----+-----------------------------+----------------------
//  sample beat    | in  | sample_valid / sample_stall | channel, sample
//  result beat    | out | result_valid / result_stall | channel_out, average
//
//  One sample beat per cycle on any channel mix while sample_stall is low,
//  set by the ring and total read-modify-write with forwarding; result_valid
//  rises once its result is written into the result buffer.
//  Reset needs no clearing pass: written and wrapped flags per channel mask
//  memory entries never written, so beats are taken right after reset.
//  With eight beats in flight or buffered, sample_stall holds until one leaves.
//
module multichannel_moving_average_core #(
  parameter int CHANNELS    = 8,
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  mma_pkg::chan_t   channel,
  input  mma_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output mma_pkg::chan_t   channel_out,
  output mma_pkg::avg_t    average
);
  import mma_pkg::*;

  localparam int TOTAL_BITS = total_bits(SAMPLE_BITS, WINDOW);
  localparam fifo_cnt_t CREDIT_MAX = fifo_cnt_t'(FIFO_DEPTH);

  logic                  accept;
  logic                  pop;
  fifo_cnt_t             credit;
  beat_ctl_t             s2_ctl;
  chan_t                 s2_channel;
  logic [TOTAL_BITS-1:0] s2_total;
  beat_ctl_t             s3_ctl;
  chan_t                 s3_channel;
  avg_t                  s3_average;

  assign accept       = sample_valid && !sample_stall;
  assign pop          = result_valid && !result_stall;
  assign sample_stall = (credit == CREDIT_MAX);

  // Beats accepted and not yet delivered; bounds the result buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      unique case ({accept, pop})
        2'b10:   credit <= credit + 1'b1;
        2'b01:   credit <= credit - 1'b1;
        default: credit <= credit;
      endcase
    end
  end

  // Ring and total update.
  mma_ring_update #(
    .CHANNELS    (CHANNELS),
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ring (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .channel    (channel),
    .sample     (sample),
    .s2_ctl     (s2_ctl),
    .s2_channel (s2_channel),
    .s2_total   (s2_total)
  );

  // Rounded average.
  mma_recip_div #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .in_ctl      (s2_ctl),
    .in_channel  (s2_channel),
    .in_total    (s2_total),
    .out_ctl     (s3_ctl),
    .out_channel (s3_channel),
    .out_average (s3_average)
  );

  // Output buffering.
  mma_out_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (s3_ctl.valid),
    .push_channel (s3_channel),
    .push_average (s3_average),
    .valid        (result_valid),
    .stall        (result_stall),
    .channel      (channel_out),
    .average      (average)
  );

  // Outstanding beats never exceed the buffer depth.
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= CREDIT_MAX)
    else $error("outstanding beat count above buffer depth");

  // A buffered result always has a matching accepted beat.
  a_result_has_credit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> credit != '0)
    else $error("result offered with no beat outstanding");

  // A result leaving the divider always has a matching accepted beat.
  a_push_has_credit: assert property (@(posedge clk) disable iff (rst)
    s3_ctl.valid |-> credit != '0)
    else $error("result produced with no beat outstanding");

endmodule

### rtl/core/mma_ring_update.sv
// ----------------------------------------------------------------------------
// Ring update stage
// Holds the sample rings and window totals in synchronous memories, keeps
// the per-channel write positions, and computes the new window total with
// read-modify-write forwarding between back-to-back beats.
// ----------------------------------------------------------------------------
module mma_ring_update #(
  parameter int CHANNELS    = 8,
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 12,
  localparam int TOTAL_BITS = mma_pkg::total_bits(SAMPLE_BITS, WINDOW)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  mma_pkg::chan_t          channel,
  input  mma_pkg::sample_t        sample,
  output mma_pkg::beat_ctl_t      s2_ctl,
  output mma_pkg::chan_t          s2_channel,
  output logic [TOTAL_BITS-1:0]   s2_total
);
  import mma_pkg::*;

  localparam int STORE_BITS = store_bits(SAMPLE_BITS);
  localparam int LIVE_CH    = (CHANNELS < PORT_CHANNELS) ? CHANNELS : PORT_CHANNELS;
  localparam int CIW        = (LIVE_CH > 1) ? $clog2(LIVE_CH) : 1;
  localparam int PW         = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DEPTH      = LIVE_CH * WINDOW;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam chan_wide_t LIVE_LIM = chan_wide_t'(LIVE_CH);
  localparam logic [PW-1:0] LAST_POS = PW'(WINDOW - 1);

  // State stores. The memories come up unknown; flags mask unwritten entries.
  logic [STORE_BITS-1:0] ring_mem  [DEPTH];
  logic [TOTAL_BITS-1:0] total_mem [LIVE_CH];
  logic [PW-1:0]         wr_pos    [LIVE_CH];
  logic [LIVE_CH-1:0]    full;
  logic [LIVE_CH-1:0]    written;

  // Accept-cycle signals.
  logic                  live0;
  logic [CIW-1:0]        idx0;
  logic [PW-1:0]         pos0;
  logic [PW-1:0]         pos0_next;
  logic                  wrap0;
  logic [AW-1:0]         addr0;
  logic [STORE_BITS-1:0] smp0;

  // Second-stage registers.
  beat_ctl_t             s1_ctl;
  chan_t                 s1_chan;
  logic [CIW-1:0]        s1_idx;
  logic [AW-1:0]         s1_addr;
  logic [STORE_BITS-1:0] s1_sample;
  logic                  s1_old_ok;
  logic                  s1_tot_ok;
  logic                  s1_fwd_ring;
  logic                  s1_fwd_total;
  logic                  s1_wr;
  logic [STORE_BITS-1:0] ring_q;
  logic [TOTAL_BITS-1:0] total_q;
  logic [STORE_BITS-1:0] last_sample;
  logic [TOTAL_BITS-1:0] last_total;
  logic [STORE_BITS-1:0] old1;
  logic [TOTAL_BITS-1:0] tot1;
  logic [TOTAL_BITS-1:0] total1_next;

  // Decode the incoming beat and find its ring slot.
  assign live0     = {1'b0, channel} < LIVE_LIM;
  assign idx0      = channel[CIW-1:0];
  assign smp0      = sample[STORE_BITS-1:0];
  assign pos0      = wr_pos[idx0];
  assign wrap0     = (pos0 == LAST_POS);
  assign pos0_next = wrap0 ? '0 : pos0 + 1'b1;
  assign addr0     = AW'(idx0) * AW'(WINDOW) + AW'(pos0);

  // Write positions advance at accept, so the next beat sees them at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      full    <= '0;
      written <= '0;
      for (int i = 0; i < LIVE_CH; i++) begin
        wr_pos[i] <= '0;
      end
    end else if (accept && live0) begin
      wr_pos[idx0]  <= pos0_next;
      written[idx0] <= 1'b1;
      if (wrap0) begin
        full[idx0] <= 1'b1;
      end
    end
  end

  // Stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl.valid <= accept;
      s1_ctl.live  <= live0;
    end
  end

  assign s1_wr = s1_ctl.valid && s1_ctl.live;

  // Stage payload and forwarding flags against the write in flight.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_chan      <= channel;
      s1_idx       <= idx0;
      s1_addr      <= addr0;
      s1_sample    <= smp0;
      s1_old_ok    <= live0 && full[idx0];
      s1_tot_ok    <= live0 && written[idx0];
      s1_fwd_ring  <= s1_wr && live0 && (s1_addr == addr0);
      s1_fwd_total <= s1_wr && live0 && (s1_idx == idx0);
    end
  end

  // Memory reads, registered.
  always_ff @(posedge clk) begin
    if (accept && live0) begin
      ring_q  <= ring_mem[addr0];
      total_q <= total_mem[idx0];
    end
  end

  // Pick the replaced sample and the current total.
  always_comb begin
    priority if (!s1_old_ok) begin
      old1 = '0;
    end else if (s1_fwd_ring) begin
      old1 = last_sample;
    end else begin
      old1 = ring_q;
    end
    priority if (!s1_tot_ok) begin
      tot1 = '0;
    end else if (s1_fwd_total) begin
      tot1 = last_total;
    end else begin
      tot1 = total_q;
    end
  end

  assign total1_next = tot1 - TOTAL_BITS'(old1) + TOTAL_BITS'(s1_sample);

  // Write back and keep a copy for the forwarding path.
  always_ff @(posedge clk) begin
    if (s1_wr) begin
      ring_mem[s1_addr] <= s1_sample;
      total_mem[s1_idx] <= total1_next;
      last_sample       <= s1_sample;
      last_total        <= total1_next;
    end
  end

  // Hand the updated total to the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else begin
      s2_ctl <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    s2_channel <= s1_chan;
    s2_total   <= total1_next;
  end

  // A ring slot collision can only come from the same channel.
  a_ring_fwd_same_chan: assert property (@(posedge clk) disable iff (rst)
    s1_ctl.valid && s1_fwd_ring |-> s1_fwd_total)
    else $error("ring forward without total forward");

  // A channel can only wrap after it has been written.
  a_full_written: assert property (@(posedge clk) disable iff (rst)
    (full & ~written) == '0)
    else $error("channel wrapped before first write");

  // A forwarded total always belongs to a channel already written.
  a_fwd_total_ok: assert property (@(posedge clk) disable iff (rst)
    s1_wr && s1_fwd_total |-> s1_tot_ok)
    else $error("total forwarded into unwritten channel");

endmodule

### rtl/core/mma_recip_div.sv
// ----------------------------------------------------------------------------
// Rounded divide by window
// Adds half a window to the total and divides by WINDOW through a multiply
// by a rounded-up reciprocal, then takes the upper bits of the product.
// ----------------------------------------------------------------------------
module mma_recip_div #(
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 12,
  localparam int TOTAL_BITS = mma_pkg::total_bits(SAMPLE_BITS, WINDOW)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mma_pkg::beat_ctl_t    in_ctl,
  input  mma_pkg::chan_t        in_channel,
  input  logic [TOTAL_BITS-1:0] in_total,
  output mma_pkg::beat_ctl_t    out_ctl,
  output mma_pkg::chan_t        out_channel,
  output mma_pkg::avg_t         out_average
);
  import mma_pkg::*;

  localparam int STORE_BITS = store_bits(SAMPLE_BITS);
  localparam int SHIFT      = TOTAL_BITS + $clog2(WINDOW);
  localparam int MUL_BITS   = TOTAL_BITS + 2;
  localparam int PROD_BITS  = TOTAL_BITS + MUL_BITS;
  localparam longint unsigned MUL = ((longint'(1) << SHIFT) + WINDOW - 1) / WINDOW;
  localparam logic [MUL_BITS-1:0]   MUL_C = MUL_BITS'(MUL);
  localparam logic [TOTAL_BITS-1:0] HALF  = TOTAL_BITS'(WINDOW / 2);

  logic [TOTAL_BITS-1:0] biased;
  logic [PROD_BITS-1:0]  prod;

  // Rounding bias; the sum stays within the total's width.
  assign biased = in_total + HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
  end

  // Reciprocal multiply, registered.
  always_ff @(posedge clk) begin
    out_channel <= in_channel;
    prod        <= PROD_BITS'(biased) * PROD_BITS'(MUL_C);
  end

  // Channels outside the configured count report zero.
  assign out_average = out_ctl.live ? AVG_BITS'(prod[SHIFT +: STORE_BITS]) : '0;

endmodule

### rtl/core/mma_out_fifo.sv
// ----------------------------------------------------------------------------
// Result buffer
// Small register FIFO that decouples the free-running datapath from the
// output channel.
// ----------------------------------------------------------------------------
module mma_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mma_pkg::chan_t   push_channel,
  input  mma_pkg::avg_t    push_average,
  output logic             valid,
  input  logic             stall,
  output mma_pkg::chan_t   channel,
  output mma_pkg::avg_t    average
);
  import mma_pkg::*;

  chan_t     fifo_chan [FIFO_DEPTH];
  avg_t      fifo_avg  [FIFO_DEPTH];
  fifo_ptr_t wr_ptr;
  fifo_ptr_t rd_ptr;
  fifo_cnt_t count;
  logic      pop;

  assign valid   = (count != '0);
  assign pop     = valid && !stall;
  assign channel = fifo_chan[rd_ptr];
  assign average = fifo_avg[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_chan[wr_ptr] <= push_channel;
      fifo_avg[wr_ptr]  <= push_average;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
